// ----- rtl/scc_pkg.sv -----
// Shared types and codes for the strongly connected components engine.
package scc_pkg;

  // Input transaction commands
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_UNSOLVED = 2'd3
  } status_e;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_ADD1,
    OP_ADD2,
    OP_SINIT,
    OP_ROOT,
    OP_ENTER,
    OP_ENTER2,
    OP_TOP,
    OP_EDGE,
    OP_LOWV,
    OP_FIN,
    OP_POP,
    OP_RET,
    OP_REL1,
    OP_REL2,
    OP_SDONE,
    OP_QRY1,
    OP_QRY2,
    OP_QRY3,
    OP_CLR,
    OP_DONE
  } op_e;

  // Datapath conditions reported back to the controller
  typedef struct packed {
    logic add_err;
    logic root_done;
    logic root_seen;
    logic cur_null;
    logic edge_skip;
    logic edge_new;
    logic edge_low;
    logic fin_pop;
    logic pop_last;
    logic has_parent;
    logic q_err;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/strongly_connected_components_top.sv -----
// Top level of the strongly connected components engine.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// add edge, solve, query node or clear graph. Every transaction yields exactly
// one result on the output channel (out_valid_o / out_stall_i) with status,
// component, alone and component_count.
// The config channel (cfg_valid_i / cfg_ready_o) writes node_count; it is
// ready only while no command is in progress.
// A solve checks each node in use as a root, enters each unvisited node,
// walks its edges, finishes each node (returning to a parent where there
// is one) and pops each component off the pending stack; the walk runs
// through state memories with registered reads, so the next command is
// held off until the solve finishes.
// One command is in flight at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is stalled.
// Reset empties all edge lists, clears the solved flag and the component
// count and sets node_count to 64; no clearing pass is needed.
// While out_stall_i is high the result holds, and a finished command waits if a result is already held.
module strongly_connected_components_top import scc_pkg::*; #(
  parameter int NODES = 64,
  parameter int EDGES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [5:0] from_node_i,
  input  logic [5:0] to_node_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] node_count_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [5:0] component_o,
  output logic       alone_o,
  output logic [6:0] component_count_o
);

  sts_t sts;
  op_e  op;
  logic accept;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .accept_o    (accept),
    .op_o        (op)
  );

  scc_datapath #(
    .NODES (NODES),
    .EDGES (EDGES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .accept_i          (accept),
    .from_i            (from_node_i),
    .to_i              (to_node_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (node_count_i),
    .out_stall_i       (out_stall_i),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .component_o       (component_o),
    .alone_o           (alone_o),
    .component_count_o (component_count_o)
  );

endmodule

// ----- rtl/scc_ctrl.sv -----
// Controller state machine that sequences edge loads, queries, clears and the solve walk.
module scc_ctrl import scc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  input  sts_t       sts_i,
  output logic       in_stall_o,
  output logic       cfg_ready_o,
  output logic       accept_o,
  output op_e        op_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ADD1, S_ADD2, S_SINIT, S_ROOT, S_ENTER, S_ENTER2, S_TOP, S_EDGE,
    S_LOWV, S_FIN, S_POP, S_RET, S_REL1, S_REL2, S_SDONE, S_QRY1, S_QRY2,
    S_QRY3, S_CLR, S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign accept_o    = in_valid_i && (state_q == S_IDLE);

  // Decode the operation for the datapath
  always_comb begin
    unique case (state_q)
      S_IDLE:   op_o = OP_IDLE;
      S_ADD1:   op_o = OP_ADD1;
      S_ADD2:   op_o = OP_ADD2;
      S_SINIT:  op_o = OP_SINIT;
      S_ROOT:   op_o = OP_ROOT;
      S_ENTER:  op_o = OP_ENTER;
      S_ENTER2: op_o = OP_ENTER2;
      S_TOP:    op_o = OP_TOP;
      S_EDGE:   op_o = OP_EDGE;
      S_LOWV:   op_o = OP_LOWV;
      S_FIN:    op_o = OP_FIN;
      S_POP:    op_o = OP_POP;
      S_RET:    op_o = OP_RET;
      S_REL1:   op_o = OP_REL1;
      S_REL2:   op_o = OP_REL2;
      S_SDONE:  op_o = OP_SDONE;
      S_QRY1:   op_o = OP_QRY1;
      S_QRY2:   op_o = OP_QRY2;
      S_QRY3:   op_o = OP_QRY3;
      S_CLR:    op_o = OP_CLR;
      S_DONE:   op_o = OP_DONE;
      default:  op_o = OP_IDLE;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_o) begin
          unique case (cmd_e'(cmd_i))
            CMD_ADD:   state_d = S_ADD1;
            CMD_SOLVE: state_d = S_SINIT;
            CMD_QUERY: state_d = S_QRY1;
            CMD_CLEAR: state_d = S_CLR;
            default:   state_d = S_CLR;
          endcase
        end
      end
      S_ADD1:   state_d = sts_i.add_err ? S_DONE : S_ADD2;
      S_ADD2:   state_d = S_DONE;
      S_SINIT:  state_d = S_ROOT;
      S_ROOT: begin
        priority if (sts_i.root_done) state_d = S_SDONE;
        else if (sts_i.root_seen)     state_d = S_ROOT;
        else                          state_d = S_ENTER;
      end
      S_ENTER:  state_d = S_ENTER2;
      S_ENTER2: state_d = S_TOP;
      S_TOP:    state_d = sts_i.cur_null ? S_FIN : S_EDGE;
      S_EDGE: begin
        priority if (sts_i.edge_skip) state_d = S_TOP;
        else if (sts_i.edge_new)      state_d = S_ENTER;
        else if (sts_i.edge_low)      state_d = S_LOWV;
        else                          state_d = S_TOP;
      end
      S_LOWV:   state_d = S_TOP;
      S_FIN:    state_d = sts_i.fin_pop ? S_POP : S_RET;
      S_POP:    state_d = sts_i.pop_last ? S_RET : S_POP;
      S_RET:    state_d = sts_i.has_parent ? S_REL1 : S_ROOT;
      S_REL1:   state_d = S_REL2;
      S_REL2:   state_d = S_TOP;
      S_SDONE:  state_d = S_DONE;
      S_QRY1:   state_d = sts_i.q_err ? S_DONE : S_QRY2;
      S_QRY2:   state_d = S_QRY3;
      S_QRY3:   state_d = S_DONE;
      S_CLR:    state_d = S_DONE;
      S_DONE:   state_d = sts_i.out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/scc_datapath.sv -----
// Datapath: edge lists, Tarjan stacks and tables, and the result register.
module scc_datapath import scc_pkg::*; #(
  parameter int NODES = 64,
  parameter int EDGES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_e        op_i,
  input  logic       accept_i,
  input  logic [5:0] from_i,
  input  logic [5:0] to_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  logic       out_stall_i,
  output sts_t       sts_o,
  output logic       out_valid_o,
  output logic [1:0] status_o,
  output logic [5:0] component_o,
  output logic       alone_o,
  output logic [6:0] component_count_o
);

  localparam int NW  = $clog2(NODES);
  localparam int DW  = $clog2(NODES + 1);
  localparam int EW  = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int EIW = $clog2(EDGES + 1);
  localparam int AW  = (DW > 6) ? DW : 6;
  localparam logic [EIW-1:0] NULLC = EIW'(EDGES);

  // Control and scalar state
  logic [6:0]     ncfg_q;
  logic [5:0]     a_q, b_q;
  logic [EIW-1:0] edges_q;
  logic           solved_q;
  logic [DW-1:0]  ccnt_q, vcnt_q, ptop_q, depth_q, r_q;
  logic [NW-1:0]  u_q, v_q, lu_q, vo_q, chl_q;
  logic [EIW-1:0] c_q;
  logic           chon_q, single_q, first_q;
  status_e        res_status_q;
  logic [NW-1:0]  res_comp_q;
  logic           res_alone_q;
  logic [NODES-1:0] hval_q, visited_q, onstk_q;

  logic           out_valid_q;
  status_e        out_status_q;
  logic [5:0]     out_comp_q;
  logic           out_alone_q;
  logic [6:0]     out_count_q;

  // Memories and their registered read data
  logic [NW-1:0]  et_m    [EDGES];
  logic [EIW-1:0] el_m    [EDGES];
  logic [EW-1:0]  head_m  [NODES];
  logic [EW-1:0]  tail_m  [NODES];
  logic [NW-1:0]  vord_m  [NODES];
  logic [NW-1:0]  low_m   [NODES];
  logic [NW-1:0]  comp_m  [NODES];
  logic           alone_m [NODES];
  logic [NW-1:0]  pend_m  [NODES];
  logic [NW-1:0]  cnode_m [NODES];
  logic [EIW-1:0] ccur_m  [NODES];

  logic [NW-1:0]  et_rd, vord_rd, low_rd, comp_rd, pend_rd, cnode_rd;
  logic [EIW-1:0] el_rd, ccur_rd;
  logic [EW-1:0]  head_rd, tail_rd;
  logic           alone_rd;

  // Nodes in use: zero acts as one, large values clamp
  logic [DW-1:0] n;
  always_comb begin
    priority if (ncfg_q == '0)      n = DW'(1);
    else if (32'(ncfg_q) > NODES)   n = DW'(NODES);
    else                            n = DW'(ncfg_q);
  end

  logic [NW-1:0]  a_idx;
  logic [EW-1:0]  k_idx;
  logic           a_bad, b_bad, full;
  logic           w_is_u;
  logic [EIW-1:0] entry_cur;
  assign a_idx     = NW'(a_q);
  assign k_idx     = EW'(edges_q);
  assign a_bad     = AW'(a_q) >= AW'(n);
  assign b_bad     = AW'(b_q) >= AW'(n);
  assign full      = edges_q >= NULLC;
  assign w_is_u    = (pend_rd == u_q);
  assign entry_cur = hval_q[v_q] ? EIW'(head_rd) : NULLC;

  // Conditions for the controller
  always_comb begin
    sts_o.add_err    = a_bad || b_bad || full;
    sts_o.root_done  = r_q >= n;
    sts_o.root_seen  = visited_q[NW'(r_q)];
    sts_o.cur_null   = c_q >= NULLC;
    sts_o.edge_skip  = DW'(et_rd) >= n;
    sts_o.edge_new   = !visited_q[et_rd] && (32'(depth_q) < NODES) &&
                       (32'(ptop_q) < NODES);
    sts_o.edge_low   = visited_q[et_rd] && onstk_q[et_rd];
    sts_o.fin_pop    = (lu_q == vo_q) && (ptop_q != '0);
    sts_o.pop_last   = w_is_u || (ptop_q == DW'(1));
    sts_o.has_parent = depth_q > DW'(1);
    sts_o.q_err      = a_bad || !solved_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Memory write ports
  logic           et_we, el_we, head_we, tail_we, vord_we, low_we;
  logic           pend_we, cnode_we, ccur_we, comp_we, alone_we;
  logic [EW-1:0]  el_wa;
  logic [EIW-1:0] el_wd, ccur_wd;
  logic [NW-1:0]  low_wa, low_wd, ccur_wa;
  logic           alone_wd;

  always_comb begin
    et_we    = (op_i == OP_ADD1) && !sts_o.add_err;
    el_we    = et_we || ((op_i == OP_ADD2) && hval_q[a_idx]);
    el_wa    = (op_i == OP_ADD2) ? tail_rd : k_idx;
    el_wd    = (op_i == OP_ADD2) ? edges_q : NULLC;
    head_we  = (op_i == OP_ADD2) && !hval_q[a_idx];
    tail_we  = (op_i == OP_ADD2);
    vord_we  = (op_i == OP_ENTER2);
    pend_we  = (op_i == OP_ENTER2);
    cnode_we = (op_i == OP_ENTER2);
    comp_we  = (op_i == OP_POP);
    alone_we = (op_i == OP_POP) && sts_o.pop_last;
    alone_wd = first_q ? w_is_u : single_q;

    ccur_we = 1'b0;
    ccur_wa = NW'(depth_q);
    ccur_wd = entry_cur;
    if (op_i == OP_ENTER2) begin
      ccur_we = 1'b1;
    end else if (op_i == OP_EDGE) begin
      ccur_we = 1'b1;
      ccur_wa = NW'(depth_q - DW'(1));
      ccur_wd = el_rd;
    end

    low_we = 1'b0;
    low_wa = u_q;
    low_wd = low_rd;
    if (op_i == OP_ENTER2) begin
      low_we = 1'b1;
      low_wa = v_q;
      low_wd = NW'(vcnt_q);
    end else if (op_i == OP_LOWV) begin
      low_we = low_rd < lu_q;
    end else if (op_i == OP_REL2) begin
      low_we = chon_q && (chl_q < low_rd);
      low_wd = chl_q;
    end
  end

  // Memory read addresses
  logic [NW-1:0] low_ra, pend_ra, frame_ra;
  assign low_ra   = (op_i == OP_EDGE) ? et_rd : cnode_rd;
  assign pend_ra  = (op_i == OP_POP) ? NW'(ptop_q - DW'(2)) : NW'(ptop_q - DW'(1));
  assign frame_ra = NW'(depth_q - DW'(2));

  // Edge store
  always_ff @(posedge clk_i) begin
    if (et_we) et_m[k_idx] <= NW'(b_q);
    if (el_we) el_m[el_wa] <= el_wd;
    et_rd <= et_m[EW'(c_q)];
    el_rd <= el_m[EW'(c_q)];
  end

  // List heads and tails
  always_ff @(posedge clk_i) begin
    if (head_we) head_m[a_idx] <= k_idx;
    if (tail_we) tail_m[a_idx] <= k_idx;
    head_rd <= head_m[v_q];
    tail_rd <= tail_m[a_idx];
  end

  // Visit order and low links
  always_ff @(posedge clk_i) begin
    if (vord_we) vord_m[v_q] <= NW'(vcnt_q);
    if (low_we) low_m[low_wa] <= low_wd;
    vord_rd <= vord_m[cnode_rd];
    low_rd  <= low_m[low_ra];
  end

  // Pending stack and call frames
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_m[NW'(ptop_q)] <= v_q;
    if (cnode_we) cnode_m[NW'(depth_q)] <= v_q;
    if (ccur_we) ccur_m[ccur_wa] <= ccur_wd;
    pend_rd  <= pend_m[pend_ra];
    cnode_rd <= cnode_m[frame_ra];
    ccur_rd  <= ccur_m[frame_ra];
  end

  // Component tables
  always_ff @(posedge clk_i) begin
    if (comp_we) comp_m[pend_rd] <= NW'(ccnt_q);
    if (alone_we) alone_m[NW'(ccnt_q)] <= alone_wd;
    comp_rd  <= comp_m[a_idx];
    alone_rd <= alone_m[comp_rd];
  end

  // Per-node flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hval_q    <= '0;
      visited_q <= '0;
      onstk_q   <= '0;
    end else begin
      unique case (op_i)
        OP_ADD2:   hval_q[a_idx] <= 1'b1;
        OP_CLR:    hval_q <= '0;
        OP_SINIT: begin
          visited_q <= '0;
          onstk_q   <= '0;
        end
        OP_ENTER2: begin
          visited_q[v_q] <= 1'b1;
          onstk_q[v_q]   <= 1'b1;
        end
        OP_POP:    onstk_q[pend_rd] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Scalar state, advanced by the current operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncfg_q       <= 7'd64;
      a_q          <= '0;
      b_q          <= '0;
      edges_q      <= '0;
      solved_q     <= 1'b0;
      ccnt_q       <= '0;
      vcnt_q       <= '0;
      ptop_q       <= '0;
      depth_q      <= '0;
      r_q          <= '0;
      u_q          <= '0;
      v_q          <= '0;
      lu_q         <= '0;
      vo_q         <= '0;
      chl_q        <= '0;
      c_q          <= '0;
      chon_q       <= 1'b0;
      single_q     <= 1'b0;
      first_q      <= 1'b0;
      res_status_q <= ST_OK;
      res_comp_q   <= '0;
      res_alone_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ncfg_q   <= cfg_data_i;
        solved_q <= 1'b0;
      end
      unique case (op_i)
        OP_IDLE: begin
          if (accept_i) begin
            a_q          <= from_i;
            b_q          <= to_i;
            res_status_q <= ST_OK;
            res_comp_q   <= '0;
            res_alone_q  <= 1'b0;
          end
        end
        OP_ADD1: begin
          if (a_bad || b_bad) res_status_q <= ST_RANGE;
          else if (full)      res_status_q <= ST_FULL;
        end
        OP_ADD2: begin
          edges_q  <= edges_q + EIW'(1);
          solved_q <= 1'b0;
        end
        OP_SINIT: begin
          ptop_q  <= '0;
          vcnt_q  <= '0;
          ccnt_q  <= '0;
          r_q     <= '0;
          depth_q <= '0;
        end
        OP_ROOT: begin
          if (!sts_o.root_done) begin
            v_q <= NW'(r_q);
            r_q <= r_q + DW'(1);
          end
        end
        OP_ENTER2: begin
          vcnt_q  <= vcnt_q + DW'(1);
          ptop_q  <= ptop_q + DW'(1);
          depth_q <= depth_q + DW'(1);
          u_q     <= v_q;
          c_q     <= entry_cur;
          lu_q    <= NW'(vcnt_q);
          vo_q    <= NW'(vcnt_q);
        end
        OP_EDGE: begin
          v_q <= et_rd;
          c_q <= el_rd;
        end
        OP_LOWV: begin
          if (low_rd < lu_q) lu_q <= low_rd;
        end
        OP_FIN: first_q <= 1'b1;
        OP_POP: begin
          ptop_q  <= ptop_q - DW'(1);
          first_q <= 1'b0;
          if (first_q) single_q <= w_is_u;
          if (sts_o.pop_last) ccnt_q <= ccnt_q + DW'(1);
        end
        OP_RET: begin
          depth_q <= depth_q - DW'(1);
          chl_q   <= lu_q;
          chon_q  <= onstk_q[u_q];
        end
        OP_REL1: begin
          u_q <= cnode_rd;
          c_q <= ccur_rd;
        end
        OP_REL2: begin
          vo_q <= vord_rd;
          lu_q <= (chon_q && (chl_q < low_rd)) ? chl_q : low_rd;
        end
        OP_SDONE: solved_q <= 1'b1;
        OP_QRY1: begin
          if (a_bad)          res_status_q <= ST_RANGE;
          else if (!solved_q) res_status_q <= ST_UNSOLVED;
        end
        OP_QRY3: begin
          res_comp_q  <= comp_rd;
          res_alone_q <= alone_rd;
        end
        OP_CLR: begin
          edges_q  <= '0;
          ccnt_q   <= '0;
          solved_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Result register: load when the slot frees, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_comp_q   <= '0;
      out_alone_q  <= 1'b0;
      out_count_q  <= '0;
    end else begin
      if ((op_i == OP_DONE) && sts_o.out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_comp_q   <= 6'(res_comp_q);
        out_alone_q  <= res_alone_q;
        out_count_q  <= 7'(ccnt_q);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign component_o       = out_comp_q;
  assign alone_o           = out_alone_q;
  assign component_count_o = out_count_q;

  // Pending stack depth never passes NODES
  a_ptop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptop_q) <= NODES)
    else $error("pending stack overflow");

  // Edge count never passes the store size
  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edges_q) <= EDGES)
    else $error("edge count overflow");

  // A pop only happens with something on the pending stack
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_POP) |-> (ptop_q != '0))
    else $error("pop from empty pending stack");

  // A finished item reaches the result register in the next cycle
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((op_i == OP_DONE) && sts_o.out_free) |=> out_valid_q)
    else $error("result not loaded");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the strongly connected components engine.
`timescale 1ns / 1ps

module tb;
  import scc_pkg::*;

  localparam int NN = 64;
  localparam int NE = 256;
  localparam int NULLK = 256;
  localparam int WATCHDOG = 200000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] cmd_i;
  logic [5:0] from_node_i, to_node_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [6:0] node_count_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] status_o;
  logic [5:0] component_o;
  logic alone_o;
  logic [6:0] component_count_o;

  strongly_connected_components_top u_dut (.*);

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] comp;
    logic       alone;
    logic [6:0] count;
  } scc_res_t;

  // Predictor state
  int unsigned p_nodes;
  int unsigned e_tgt[NE], e_lnk[NE], l_head[NN], l_tail[NN];
  int unsigned n_edges, n_comp;
  bit p_solved;
  bit vis[NN], onst[NN], calone[NN];
  int unsigned vord[NN], low[NN], pend[NN], cnode[NN], ccur[NN], ncomp[NN];
  int unsigned ptop, vcnt;

  scc_res_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_gaps = 1, out_gaps = 1;

  function automatic void record_expected(scc_res_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic int unsigned live_nodes();
    if (p_nodes == 0) return 1;
    if (p_nodes > NN) return NN;
    return p_nodes;
  endfunction

  function automatic void graph_clear();
    for (int i = 0; i < NN; i++) begin
      l_head[i] = NULLK;
      l_tail[i] = NULLK;
    end
    n_edges = 0;
    n_comp = 0;
    p_solved = 0;
  endfunction

  function automatic void visit(int unsigned v, ref int unsigned d);
    vis[v] = 1; vord[v] = vcnt; low[v] = vcnt; vcnt++;
    pend[ptop] = v; ptop++; onst[v] = 1;
    cnode[d] = v; ccur[d] = l_head[v]; d++;
  endfunction

  // Iterative Tarjan walk
  function automatic void find_components();
    int unsigned n, d, u, c, v, w, id, p;
    bit single;
    n = live_nodes();
    d = 0;
    for (int i = 0; i < NN; i++) begin
      vis[i] = 0; onst[i] = 0;
    end
    ptop = 0; vcnt = 0; n_comp = 0;
    for (int r = 0; r < n; r++) begin
      if (vis[r]) continue;
      visit(r, d);
      while (d > 0) begin
        u = cnode[d-1];
        c = ccur[d-1];
        if (c < NE) begin
          v = e_tgt[c];
          ccur[d-1] = e_lnk[c];
          if (v >= n) continue;
          if (!vis[v]) begin
            if (d < NN && ptop < NN) visit(v, d);
          end else if (onst[v] && low[v] < low[u]) begin
            low[u] = low[v];
          end
        end else begin
          if (low[u] == vord[u] && ptop > 0) begin
            id = n_comp;
            single = (pend[ptop-1] == u);
            while (ptop > 0) begin
              w = pend[ptop-1];
              ptop--;
              onst[w] = 0;
              ncomp[w] = id;
              if (w == u) break;
            end
            if (id < NN) calone[id] = single;
            n_comp++;
          end
          d--;
          if (d > 0) begin
            p = cnode[d-1];
            if (onst[u] && low[u] < low[p]) low[p] = low[u];
          end
        end
      end
    end
    p_solved = 1;
  endfunction

  function automatic scc_res_t predict_result(logic [1:0] cmd, int unsigned a, int unsigned b);
    scc_res_t r;
    int unsigned n, k;
    n = live_nodes();
    r = '0;
    case (cmd)
      CMD_ADD: begin
        if (a >= n || b >= n) r.status = ST_RANGE;
        else if (n_edges >= NE) r.status = ST_FULL;
        else begin
          k = n_edges;
          e_tgt[k] = b;
          e_lnk[k] = NULLK;
          if (l_tail[a] < NE) e_lnk[l_tail[a]] = k;
          else l_head[a] = k;
          l_tail[a] = k;
          n_edges++;
          p_solved = 0;
        end
      end
      CMD_SOLVE: find_components();
      CMD_QUERY: begin
        if (a >= n) r.status = ST_RANGE;
        else if (!p_solved) r.status = ST_UNSOLVED;
        else begin
          r.comp = ncomp[a][5:0];
          r.alone = calone[ncomp[a] % NN];
        end
      end
      default: graph_clear();
    endcase
    r.count = n_comp[6:0];
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Output stall and result checking
  initial begin
    out_stall_i = 0;
    forever begin
      @(negedge clk_i);
      if (out_gaps && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1;
        repeat (1 + gap_len()) @(negedge clk_i);
      end
      out_stall_i <= 0;
    end
  end

  always @(posedge clk_i) begin
    scc_res_t exp_r, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, component_o, alone_o, component_count_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        if (got.comp !== exp_r.comp)
          $display("%0t: component expected %0d actual %0d", $time, exp_r.comp, got.comp);
        if (got.alone !== exp_r.alone)
          $display("%0t: alone expected %0d actual %0d", $time, exp_r.alone, got.alone);
        if (got.count !== exp_r.count)
          $display("%0t: component_count expected %0d actual %0d", $time, exp_r.count,
                   got.count);
        if (got !== exp_r) errors++;
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("strongly_connected_components_top regression: fail");
      $finish;
    end
  end

  // Send one command; optionally check against a typed-in result too
  task automatic send_cmd(logic [1:0] cmd, logic [5:0] a, logic [5:0] b,
                          bit has_fixed = 0, scc_res_t fixed = '0);
    scc_res_t r;
    repeat (1 + (in_gaps ? gap_len() : 0)) @(negedge clk_i);
    in_valid_i <= 1;
    cmd_i <= cmd;
    from_node_i <= a;
    to_node_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_result(cmd, 32'(a), 32'(b));
    if (has_fixed && r !== fixed) begin
      $display("%0t: table row expected %h predictor %h", $time, fixed, r);
      errors++;
    end
    record_expected(r);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_nodes(logic [6:0] v);
    drain();
    cfg_valid_i <= 1;
    node_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    p_nodes = 32'(v);
    p_solved = 0;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  typedef struct {
    logic [1:0] cmd;
    logic [5:0] a, b;
    bit has_fixed;
    scc_res_t fixed;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{CMD_QUERY, 6'd0,  6'd0,  1, '{ST_UNSOLVED, 6'd0, 1'b0, 7'd0}},
    '{CMD_SOLVE, 6'd0,  6'd0,  1, '{ST_OK, 6'd0, 1'b0, 7'd64}},
    '{CMD_QUERY, 6'd63, 6'd0,  1, '{ST_OK, 6'd63, 1'b1, 7'd64}},
    '{CMD_ADD,   6'd0,  6'd63, 1, '{ST_OK, 6'd0, 1'b0, 7'd64}},
    '{CMD_QUERY, 6'd0,  6'd0,  1, '{ST_UNSOLVED, 6'd0, 1'b0, 7'd64}},
    '{CMD_ADD,   6'd63, 6'd0,  0, '0},
    '{CMD_ADD,   6'd5,  6'd5,  0, '0},
    '{CMD_ADD,   6'd1,  6'd2,  0, '0},
    '{CMD_ADD,   6'd2,  6'd1,  0, '0},
    '{CMD_SOLVE, 6'd0,  6'd0,  0, '0},
    '{CMD_QUERY, 6'd0,  6'd0,  0, '0},
    '{CMD_QUERY, 6'd63, 6'd0,  0, '0},
    '{CMD_QUERY, 6'd5,  6'd0,  0, '0},
    '{CMD_QUERY, 6'd1,  6'd0,  0, '0},
    '{CMD_CLEAR, 6'd0,  6'd0,  1, '{ST_OK, 6'd0, 1'b0, 7'd0}},
    '{CMD_QUERY, 6'd3,  6'd0,  1, '{ST_UNSOLVED, 6'd0, 1'b0, 7'd0}}
  };

  // Random chain/cycle graphs plus noise over the current node count
  task automatic random_phase(int items);
    int unsigned n, k, a;
    n = live_nodes();
    k = 0;
    while (k < items) begin
      case ($urandom_range(0, 9))
        0: begin send_cmd(CMD_CLEAR, 6'($urandom), 6'($urandom)); k++; end
        1: begin send_cmd(CMD_ADD, 6'($urandom), 6'($urandom)); k++; end
        2: begin send_cmd(CMD_QUERY, 6'($urandom), 6'($urandom)); k++; end
        default: begin
          // chain of random nodes, then solve and query
          a = $urandom_range(0, n - 1);
          repeat ($urandom_range(1, 5)) begin
            int unsigned b;
            b = $urandom_range(0, n - 1);
            send_cmd(CMD_ADD, 6'(a), 6'(b));
            a = b;
            k++;
          end
          send_cmd(CMD_SOLVE, 6'($urandom), 6'($urandom));
          repeat ($urandom_range(1, 4))
            send_cmd(CMD_QUERY, 6'($urandom_range(0, n - 1)), 6'd0);
          k += 3;
        end
      endcase
    end
  endtask

  initial begin
    in_valid_i = 0;
    cmd_i = CMD_ADD;
    from_node_i = 0;
    to_node_i = 0;
    cfg_valid_i = 0;
    node_count_i = 7'd64;
    rst_ni = 0;
    p_nodes = 64;
    n_comp = 0;
    graph_clear();
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    foreach (directed[i])
      send_cmd(directed[i].cmd, directed[i].a, directed[i].b,
               directed[i].has_fixed, directed[i].fixed);

    // Fill the edge store, then overflow it
    in_gaps = 0;
    repeat (NE + 2) send_cmd(CMD_ADD, 6'($urandom), 6'($urandom));
    in_gaps = 1;
    send_cmd(CMD_SOLVE, 6'd0, 6'd0);
    send_cmd(CMD_QUERY, 6'($urandom), 6'd0);
    send_cmd(CMD_CLEAR, 6'd0, 6'd0);

    set_nodes(7'd1);
    send_cmd(CMD_ADD, 6'd0, 6'd0);
    send_cmd(CMD_ADD, 6'd1, 6'd0);
    send_cmd(CMD_SOLVE, 6'd0, 6'd0);
    send_cmd(CMD_QUERY, 6'd0, 6'd0);
    send_cmd(CMD_QUERY, 6'd1, 6'd0);
    random_phase(40);

    set_nodes(7'd0);
    random_phase(20);
    set_nodes(7'd8);
    random_phase(120);
    set_nodes(7'd127);
    random_phase(40);
    set_nodes(7'd3);
    out_gaps = 0;
    random_phase(60);
    out_gaps = 1;
    set_nodes(7'd16);
    random_phase(90);
    set_nodes(7'd64);
    random_phase(50);

    drain();
    if (errors == 0)
      $display("strongly_connected_components_top regression: pass");
    else
      $display("strongly_connected_components_top regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/scc_pkg.sv
rtl/scc_ctrl.sv
rtl/scc_datapath.sv
rtl/strongly_connected_components_top.sv
tb/tb.sv
